// File: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared constants, types and the character map of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int MAX_BEATS = 3;
    localparam int BEAT_WIDTH = $clog2(MAX_BEATS + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BEAT_WIDTH-1:0] beat_t;

    // Results caused by one accepted word, handed to the output side at once.
    typedef struct packed {
        beat_t            beats;
        logic             done;
        logic [2:0][7:0]  data;
        count_t [2:0]     counts;
    } burst_t;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            s = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            s = 6'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]}) begin
            s = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == CHAR_PLUS) begin
            s = 6'd62;
        end
        else if (c == CHAR_SLASH) begin
            s = 6'd63;
        end
        return s;
    endfunction

    function automatic count_t sat_inc(input count_t t);
        return (t == COUNT_MAX) ? t : count_t'(t + 1'b1);
    endfunction

endpackage

// File: hw/rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_enc_if / b64d_dec_if
// Valid/ready channels for encoded characters and decoded results.
// ----------------------------------------------------------------------------
interface b64d_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

interface b64d_dec_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_of_run;
    logic        stream_done;
    logic [15:0] byte_count;

    modport source (output valid, output data_byte, output has_byte,
                    output last_of_run, output stream_done, output byte_count,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte,
                  input last_of_run, input stream_done, input byte_count,
                  output ready);
endinterface

// File: hw/rtl/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Group state, character map and byte count; builds the results of one word.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_char,
    input  logic             end_of_text,
    output b64d_pkg::burst_t burst
);
    import b64d_pkg::*;

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        pad_seen_reg, pad_seen_next;
    logic        pad_pending_reg, pad_pending_next;
    count_t      total_reg, total_next;

    logic [23:0] acc_shift;
    count_t      c1, c2, c3;

    assign acc_shift = {acc_reg[17:0], sextet_of(in_char)};
    assign c1 = sat_inc(total_reg);
    assign c2 = sat_inc(c1);
    assign c3 = sat_inc(c2);

    always_comb
    begin
        acc_next         = acc_reg;
        pos_next         = pos_reg;
        pad_seen_next    = pad_seen_reg;
        pad_pending_next = pad_pending_reg;
        total_next       = total_reg;
        burst.beats      = '0;
        burst.done       = 1'b0;
        burst.data       = '0;
        burst.counts     = {c3, c2, c1};

        if (end_of_text) begin
            burst.beats      = beat_t'(1);
            burst.done       = 1'b1;
            burst.counts[0]  = total_reg;
            acc_next         = '0;
            pos_next         = '0;
            pad_seen_next    = 1'b0;
            pad_pending_next = 1'b0;
            total_next       = '0;
        end
        else if (pad_seen_reg) begin
            if (pos_reg == 2'd3) begin
                if (pad_pending_reg) begin
                    burst.beats   = beat_t'(1);
                    burst.data[0] = acc_reg[11:4];
                    total_next    = c1;
                end
                acc_next         = '0;
                pos_next         = '0;
                pad_seen_next    = 1'b0;
                pad_pending_next = 1'b0;
            end
            else begin
                pos_next = pos_reg + 2'd1;
            end
        end
        else if (pos_reg == 2'd0 && (in_char == CHAR_CR || in_char == CHAR_LF)) begin
            pos_next = pos_reg;
        end
        else if (in_char == CHAR_PAD) begin
            if (pos_reg == 2'd3) begin
                burst.beats   = beat_t'(2);
                burst.data[0] = acc_reg[17:10];
                burst.data[1] = acc_reg[9:2];
                total_next    = c2;
                acc_next      = '0;
                pos_next      = '0;
            end
            else begin
                pad_seen_next    = 1'b1;
                pad_pending_next = (pos_reg == 2'd2);
                pos_next         = pos_reg + 2'd1;
            end
        end
        else begin
            if (pos_reg == 2'd3) begin
                burst.beats   = beat_t'(3);
                burst.data[0] = acc_shift[23:16];
                burst.data[1] = acc_shift[15:8];
                burst.data[2] = acc_shift[7:0];
                total_next    = c3;
                acc_next      = '0;
                pos_next      = '0;
            end
            else begin
                acc_next = acc_shift;
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg         <= '0;
            pos_reg         <= '0;
            pad_seen_reg    <= 1'b0;
            pad_pending_reg <= 1'b0;
            total_reg       <= '0;
        end
        else if (accept) begin
            acc_reg         <= acc_next;
            pos_reg         <= pos_next;
            pad_seen_reg    <= pad_seen_next;
            pad_pending_reg <= pad_pending_next;
            total_reg       <= total_next;
        end
    end

endmodule

// File: hw/rtl/b64d_serializer.sv
// ----------------------------------------------------------------------------
// b64d_serializer
// Holds the results of one word and sends them out one word at a time.
// ----------------------------------------------------------------------------
module b64d_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  b64d_pkg::burst_t burst,
    output logic             slot_free,
    b64d_dec_if.source       dec
);
    import b64d_pkg::*;

    burst_t burst_reg;
    logic   busy_reg;
    beat_t  idx_reg;
    logic   last_beat;
    logic   fire;

    assign last_beat = (idx_reg == beat_t'(burst_reg.beats - 1'b1));
    assign fire      = busy_reg && dec.ready;
    assign slot_free = !busy_reg || (dec.ready && last_beat);

    assign dec.valid       = busy_reg;
    assign dec.has_byte    = !burst_reg.done;
    assign dec.stream_done = burst_reg.done;
    assign dec.last_of_run = last_beat;

    always_comb
    begin
        case (idx_reg)
            beat_t'(1):
            begin
                dec.data_byte  = burst_reg.data[1];
                dec.byte_count = OUT_COUNT_WIDTH'(burst_reg.counts[1]);
            end
            beat_t'(2):
            begin
                dec.data_byte  = burst_reg.data[2];
                dec.byte_count = OUT_COUNT_WIDTH'(burst_reg.counts[2]);
            end
            default:
            begin
                dec.data_byte  = burst_reg.data[0];
                dec.byte_count = OUT_COUNT_WIDTH'(burst_reg.counts[0]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fire) begin
            if (last_beat) begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 decoder taking one encoded character per word and giving bytes.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   enc      in   in_char[7:0], end_of_text
//   dec      out  data_byte[7:0], has_byte, last_of_run, stream_done,
//                 byte_count[15:0]
//
// A taken character updates the group state at the edge of its handshake.
// A group's bytes or the end-of-text terminator leave a result register one
// word per cycle while dec is ready, so a word causing three bytes holds enc
// until its last byte leaves. A new word is taken in the cycle the last
// pending result leaves. Reset clears the group state and the byte count.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    b64d_enc_if.sink    enc,
    b64d_dec_if.source  dec
);
    import b64d_pkg::*;

    burst_t burst;
    logic   slot_free;
    logic   accept;

    assign enc.ready = slot_free;
    assign accept    = enc.valid && slot_free;

    b64d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_char     (enc.in_char),
        .end_of_text (enc.end_of_text),
        .burst       (burst)
    );

    b64d_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && (burst.beats != '0)),
        .burst     (burst),
        .slot_free (slot_free),
        .dec       (dec)
    );

endmodule

// File: dv/base64_stream_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_tb
// Self-checking bench for the streaming base64 decoder. Encoded characters go
// in one word at a time and a bit-exact predictor of the group logic works out
// the byte words and end-of-text terminators due. Every result word is checked
// field by field in order. The run covers directed corner cases, random
// well-formed and broken streams under several idle and stall patterns, and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit_tb;

    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        last_of_run;
        logic        stream_done;
        logic [15:0] byte_count;
    } dec_word_t;

    class byte_predictor;
        dec_word_t   pending_bytes[$];
        dec_word_t   run_words[$];
        logic [23:0] sextets;
        logic [1:0]  slot;
        logic        pad_hit;
        logic        pad_one_byte;
        count_t      total;
        int          errors;
        int          chars_taken;
        int          words_checked;
        int          streams_closed;

        function new();
            clear_group();
            total = '0;
        endfunction

        function void clear_group();
            sextets = '0;
            slot = '0;
            pad_hit = 1'b0;
            pad_one_byte = 1'b0;
        endfunction

        function logic [5:0] char_to_bits(logic [7:0] c);
            if (c >= "A" && c <= "Z")
            begin
                return 6'(c - "A");
            end
            if (c >= "a" && c <= "z")
            begin
                return 6'(c - "a" + 26);
            end
            if (c >= "0" && c <= "9")
            begin
                return 6'(c - "0" + 52);
            end
            if (c == CHAR_PLUS)
            begin
                return 6'd62;
            end
            if (c == CHAR_SLASH)
            begin
                return 6'd63;
            end
            return 6'd0;
        endfunction

        function void emit_byte(logic [7:0] b);
            dec_word_t w;
            if (total != COUNT_MAX)
            begin
                total = total + 1'b1;
            end
            w.data_byte = b;
            w.has_byte = 1'b1;
            w.last_of_run = 1'b0;
            w.stream_done = 1'b0;
            w.byte_count = 16'(total);
            run_words.push_back(w);
        endfunction

        function void take_char(logic [7:0] c, logic eot);
            dec_word_t w;
            chars_taken++;
            run_words.delete();
            if (eot)
            begin
                w.data_byte = 8'h00;
                w.has_byte = 1'b0;
                w.last_of_run = 1'b1;
                w.stream_done = 1'b1;
                w.byte_count = 16'(total);
                pending_bytes.push_back(w);
                clear_group();
                total = '0;
                streams_closed++;
                return;
            end
            if (pad_hit)
            begin
                if (slot == 2'd3)
                begin
                    if (pad_one_byte)
                    begin
                        emit_byte(sextets[11:4]);
                    end
                    clear_group();
                end
                else
                begin
                    slot++;
                end
            end
            else if (slot == 2'd0 && (c == CHAR_CR || c == CHAR_LF))
            begin
                return;
            end
            else if (c == CHAR_PAD)
            begin
                if (slot == 2'd3)
                begin
                    emit_byte(sextets[17:10]);
                    emit_byte(sextets[9:2]);
                    clear_group();
                end
                else
                begin
                    pad_hit = 1'b1;
                    pad_one_byte = (slot == 2'd2);
                    slot++;
                end
            end
            else
            begin
                sextets = {sextets[17:0], char_to_bits(c)};
                if (slot == 2'd3)
                begin
                    emit_byte(sextets[23:16]);
                    emit_byte(sextets[15:8]);
                    emit_byte(sextets[7:0]);
                    clear_group();
                end
                else
                begin
                    slot++;
                end
            end
            if (run_words.size() > 0)
            begin
                run_words[$].last_of_run = 1'b1;
            end
            foreach (run_words[i])
            begin
                pending_bytes.push_back(run_words[i]);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(dec_word_t got);
            dec_word_t want;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = pending_bytes.pop_front();
            words_checked++;
            if (got.data_byte !== want.data_byte)
            begin
                report_mismatch($sformatf("data_byte %h, predicted %h",
                                          got.data_byte, want.data_byte));
            end
            if (got.has_byte !== want.has_byte)
            begin
                report_mismatch($sformatf("has_byte %b, predicted %b",
                                          got.has_byte, want.has_byte));
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                report_mismatch($sformatf("last_of_run %b, predicted %b",
                                          got.last_of_run, want.last_of_run));
            end
            if (got.stream_done !== want.stream_done)
            begin
                report_mismatch($sformatf("stream_done %b, predicted %b",
                                          got.stream_done, want.stream_done));
            end
            if (got.byte_count !== want.byte_count)
            begin
                report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                          got.byte_count, want.byte_count));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    b64d_enc_if enc_ch();
    b64d_dec_if dec_ch();

    base64_stream_decoder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc_ch),
        .dec   (dec_ch)
    );

    byte_predictor sb;
    int send_idle_pct;
    int stall_pct;
    int words_sent;
    int hold_requests;
    int hold_served;
    int hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            dec_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            dec_ch.ready <= 1'b0;
            hold_left <= 80;
            hold_served <= hold_served + 1;
        end
        else
        begin
            dec_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (enc_ch.valid && enc_ch.ready)
            begin
                sb.take_char(enc_ch.in_char, enc_ch.end_of_text);
            end
            if (dec_ch.valid && dec_ch.ready)
            begin
                sb.check_result({dec_ch.data_byte, dec_ch.has_byte, dec_ch.last_of_run,
                                 dec_ch.stream_done, dec_ch.byte_count});
            end
        end
    end

    function automatic logic [7:0] sextet_to_char(int v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] any_alpha();
        return sextet_to_char($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] any_line_break();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eot);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            enc_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        enc_ch.valid <= 1'b1;
        enc_ch.in_char <= c;
        enc_ch.end_of_text <= eot;
        @(posedge clk);
        while (!enc_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_stream(input int n_groups);
        int g;
        int k;
        int cut;
        for (g = 0; g < n_groups; g++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_word(any_line_break(), 1'b0);
            end
            case ($urandom_range(0, 12))
                7:
                begin
                    for (k = 0; k < 3; k++)
                    begin
                        send_word(any_alpha(), 1'b0);
                    end
                    send_word(CHAR_PAD, 1'b0);
                end
                8:
                begin
                    send_word(any_alpha(), 1'b0);
                    send_word(any_alpha(), 1'b0);
                    send_word(CHAR_PAD, 1'b0);
                    send_word(CHAR_PAD, 1'b0);
                end
                9:
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                10:
                begin
                    cut = $urandom_range(0, 1);
                    for (k = 0; k < cut; k++)
                    begin
                        send_word(any_alpha(), 1'b0);
                    end
                    send_word(CHAR_PAD, 1'b0);
                    for (k = cut; k < 3; k++)
                    begin
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                11:
                begin
                    send_word(any_alpha(), 1'b0);
                    send_word(any_line_break(), 1'b0);
                    send_word(any_alpha(), 1'b0);
                    send_word(any_alpha(), 1'b0);
                end
                12:
                begin
                    cut = $urandom_range(1, 3);
                    for (k = 0; k < cut; k++)
                    begin
                        send_word(any_alpha(), 1'b0);
                    end
                    g = n_groups;
                end
                default:
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        send_word(any_alpha(), 1'b0);
                    end
                end
            endcase
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        enc_ch.valid <= 1'b0;
        while (sb.pending_bytes.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_traffic(input int idle, input int stall, input int n_words);
        int first;
        send_idle_pct = idle;
        stall_pct = stall;
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            send_stream($urandom_range(1, 5));
        end
        wait_drained();
    endtask

    initial
    begin
        logic [7:0] script[$];
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        words_sent = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        rst_n = 1'b0;
        enc_ch.valid = 1'b0;
        enc_ch.in_char = 8'h00;
        enc_ch.end_of_text = 1'b0;
        dec_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        script = '{"a", "z", "9", CHAR_PAD, CHAR_CR, CHAR_LF,
                   "Z", CHAR_SLASH, CHAR_PAD, CHAR_PAD,
                   CHAR_PAD, CHAR_CR, CHAR_PAD, CHAR_LF,
                   CHAR_PLUS, 8'h00, 8'h7F, CHAR_CR,
                   "A", CHAR_PAD, 8'hFF, "0",
                   "Q", "9"};
        foreach (script[i])
        begin
            send_word(script[i], 1'b0);
        end
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        wait_drained();

        run_traffic(0, 0, 20);
        run_traffic(72, 0, 20);
        run_traffic(0, 72, 20);
        run_traffic(31, 31, 20);

        // The receiver holds off while the sender keeps offering words.
        send_idle_pct = 0;
        stall_pct = 20;
        hold_requests <= hold_requests + 1;
        send_stream(4);
        wait_drained();

        if (sb.pending_bytes.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.pending_bytes.size()));
        end
        $display("Run covered %0d characters and %0d result words over %0d streams.",
                 sb.chars_taken, sb.words_checked, sb.streams_closed);
        $display("Traffic mixed idle, stall and receiver hold-off patterns.");
        if (sb.errors == 0)
        begin
            $display("base64_stream_decoder_unit regression: pass");
        end
        else
        begin
            $display("base64_stream_decoder_unit regression: fail");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("base64_stream_decoder_unit regression: fail");
        $finish;
    end

endmodule

// File: base64_stream_decoder_unit.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_if.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_serializer.sv
hw/rtl/base64_stream_decoder_unit.sv
dv/base64_stream_decoder_unit_tb.sv
